// File: src/qe_pkg.sv
// Shared constants, types and the arctangent table for the ellipticity pipeline.
`default_nettype none

package qe_pkg;

    localparam int MOM_W         = 32;
    localparam int SUM_W         = MOM_W + 2;
    localparam int D_W           = SUM_W + 1;
    localparam int ROOT_W        = 32;
    localparam int RAD_W         = 2 * ROOT_W;
    localparam int REM_W         = ROOT_W + 4;
    localparam int SQ_CELLS      = RAD_W / 2;
    localparam int MAG_CELLS     = 16;
    localparam int DIV_CELLS     = 16;
    localparam int DIV_W         = 52;
    localparam int DVS_W         = 51;
    localparam int FRAC_E        = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int NORM_STEPS    = 6;
    localparam int NORM_MSB      = 40;
    localparam int CM_W          = NORM_MSB + 2;
    localparam int CX_W          = 46;
    localparam int Z_W           = 24;
    localparam int ANG_W         = 14;
    localparam int MAG_W         = 15;
    localparam int E_W           = 16;
    localparam int ANG_LIMIT     = 4500;
    localparam int PIPE_DEPTH    = 3 + SQ_CELLS + 2 + DIV_CELLS + 3 + MAG_CELLS + 1
                                   + NORM_STEPS + CORDIC_STAGES + 1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NEGDET = 2'd1,
        ST_ZERO   = 2'd2
    } status_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  val;
    } sqrt_t;

    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [DVS_W-1:0]     dv;
        logic [DIV_CELLS-1:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // everything that rides alongside the arithmetic chains
    typedef struct packed {
        logic                    q12neg;
        logic                    cflag;
        logic                    neg;
        logic                    zero;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] diff;
        logic signed [SUM_W-1:0] y2;
        logic                    sgn1;
        logic                    sgn2;
        logic                    ovf1;
        logic                    ovf2;
        logic signed [E_W-1:0]   e1;
        logic signed [E_W-1:0]   e2;
        logic [MAG_W-1:0]        em;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic [CM_W-1:0]         cm;
    } side_t;

    // atan(2^-i) in centidegrees, 8 fraction bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] a;
        unique case (idx)
            5'd0:    a = 24'sd1152000;
            5'd1:    a = 24'sd680065;
            5'd2:    a = 24'sd359328;
            5'd3:    a = 24'sd182400;
            5'd4:    a = 24'sd91554;
            5'd5:    a = 24'sd45822;
            5'd6:    a = 24'sd22916;
            5'd7:    a = 24'sd11459;
            5'd8:    a = 24'sd5730;
            5'd9:    a = 24'sd2865;
            5'd10:   a = 24'sd1432;
            5'd11:   a = 24'sd716;
            5'd12:   a = 24'sd358;
            5'd13:   a = 24'sd179;
            5'd14:   a = 24'sd90;
            5'd15:   a = 24'sd45;
            5'd16:   a = 24'sd22;
            5'd17:   a = 24'sd11;
            5'd18:   a = 24'sd6;
            5'd19:   a = 24'sd3;
            5'd20:   a = 24'sd1;
            5'd21:   a = 24'sd1;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: src/qe_sqrt_cell.sv
// One radix-4 digit of a restoring integer square root.
`default_nettype none

module qe_sqrt_cell
    import qe_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  sqrt_t cell_in,
    output sqrt_t cell_out
);

    sqrt_t            cell_reg;
    sqrt_t            cell_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
        rem_sh = {cell_in.rem[REM_W-3:0], cell_in.val[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, cell_in.root, 2'b01};
        ge     = (rem_sh >= trial);
        cell_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        cell_next.root = {cell_in.root[ROOT_W-2:0], ge};
        cell_next.val  = {cell_in.val[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// File: src/qe_div_cell.sv
// One quotient bit of a restoring divider; divisor halves on its way down the row.
`default_nettype none

module qe_div_cell
    import qe_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  div_t cell_in,
    output div_t cell_out
);

    div_t             cell_reg;
    div_t             cell_next;
    logic [DIV_W-1:0] dv_ext;
    logic             ge;

    always_comb begin
        dv_ext = DIV_W'(cell_in.dv);
        ge     = (cell_in.rem >= dv_ext);
        cell_next.rem = ge ? (cell_in.rem - dv_ext) : cell_in.rem;
        cell_next.dv  = cell_in.dv >> 1;
        cell_next.quo = {cell_in.quo[DIV_CELLS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// File: src/qe_cordic_cell.sv
// One vectoring CORDIC rotation; shifted operands and angle come from the row.
`default_nettype none

module qe_cordic_cell
    import qe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   en,
    input  cordic_t                cell_in,
    input  logic signed [CX_W-1:0] x_shift,
    input  logic signed [CX_W-1:0] y_shift,
    input  logic signed [Z_W-1:0]  angle,
    output cordic_t                cell_out
);

    cordic_t cell_reg;
    cordic_t cell_next;
    logic    pos;

    always_comb begin
        pos = (cell_in.y > 0);
        if (pos) begin
            cell_next.x = cell_in.x + y_shift;
            cell_next.y = cell_in.y - x_shift;
            cell_next.z = cell_in.z + angle;
        end else begin
            cell_next.x = cell_in.x - y_shift;
            cell_next.y = cell_in.y + x_shift;
            cell_next.z = cell_in.z - angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// File: src/quadrupole_ellipticity.sv
// Ellipticity, magnitude and orientation from quadrupole second moments.
//
// Input channel s_*: one beat carries Q11, Q12, Q22 (signed, 16 fraction bits).
// Result channel m_*: one beat per input beat, in order: e1, e2 (14 fraction
// bits, saturated), magnitude, orientation in 0.01 degree and a status code
// (0 ok, 1 negative determinant clamped to zero, 2 zero denominator, all
// fields zero).
// The block is a fixed pipeline of 96 stages: products, a 32-cell square
// root of the determinant, a 16-cell divider pair, a 16-cell root for the
// magnitude, a 6-step normalizer and 16 CORDIC cells. A new beat is taken
// every cycle while no result waits untaken at the output.
// A result that is not taken holds the output register and freezes the whole
// pipeline; s_ready drops in that same cycle and returns with m_ready.
// Reset (aresetn low, synchronous) empties the pipeline; no result is left
// pending and the block accepts input in the first cycle after reset.
`default_nettype none

module quadrupole_ellipticity
    import qe_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [MOM_W-1:0] s_moment_xx,
    input  logic signed [MOM_W-1:0] s_moment_xy,
    input  logic signed [MOM_W-1:0] s_moment_yy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [E_W-1:0]   m_ellip_one,
    output logic signed [E_W-1:0]   m_ellip_two,
    output logic [MAG_W-1:0]        m_ellip_mag,
    output logic signed [ANG_W-1:0] m_angle_centideg,
    output logic [1:0]              m_status
);

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    assign adv     = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_DEPTH-1];
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- input, products, determinant ----------------
    logic signed [MOM_W-1:0]   q11_reg, q12_reg, q22_reg;
    logic signed [2*MOM_W-1:0] p_reg, s_reg;
    side_t                     side1_reg, side1_next;
    side_t                     side2_reg, side2_next;
    logic [RAD_W-1:0]          det_reg, det_next;
    logic signed [CX_W-1:0]    cy_abs;

    always_comb begin
        side1_next        = '0;
        side1_next.sum    = SUM_W'(q11_reg) + SUM_W'(q22_reg);
        side1_next.diff   = SUM_W'(q11_reg) - SUM_W'(q22_reg);
        side1_next.y2     = SUM_W'(q12_reg) <<< 1;
        side1_next.q12neg = q12_reg[MOM_W-1];
        side1_next.cflag  = (q11_reg != q22_reg) && (q12_reg != '0);
    end

    always_comb begin
        side2_next = side1_reg;
        if (p_reg < s_reg) begin
            det_next       = '0;
            side2_next.neg = 1'b1;
        end else begin
            det_next       = RAD_W'(p_reg - s_reg);
            side2_next.neg = 1'b0;
        end
        // fold into the right half plane
        if (side1_reg.diff < 0) begin
            side2_next.cx = -CX_W'(side1_reg.diff);
            side2_next.cy = -CX_W'(side1_reg.y2);
        end else begin
            side2_next.cx = CX_W'(side1_reg.diff);
            side2_next.cy = CX_W'(side1_reg.y2);
        end
        cy_abs = (side2_next.cy < 0) ? -side2_next.cy : side2_next.cy;
        side2_next.cm = (side2_next.cx > cy_abs) ? CM_W'(side2_next.cx) : CM_W'(cy_abs);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q11_reg   <= s_moment_xx;
            q12_reg   <= s_moment_xy;
            q22_reg   <= s_moment_yy;
            p_reg     <= q11_reg * q22_reg;
            s_reg     <= q12_reg * q12_reg;
            side1_reg <= side1_next;
            side2_reg <= side2_next;
            det_reg   <= det_next;
        end
    end

    // ---------------- square root of the determinant ----------------
    sqrt_t sq_in  [SQ_CELLS];
    sqrt_t sq_out [SQ_CELLS];
    side_t sq_side_reg [SQ_CELLS];

    genvar gi;
    generate
        for (gi = 0; gi < SQ_CELLS; gi++) begin : g_sq
            if (gi == 0) begin : g_first
                assign sq_in[gi] = '{rem: '0, root: '0, val: det_reg};
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        sq_side_reg[gi] <= side2_reg;
                    end
                end
            end else begin : g_next
                assign sq_in[gi] = sq_out[gi-1];
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        sq_side_reg[gi] <= sq_side_reg[gi-1];
                    end
                end
            end
            qe_sqrt_cell u_cell (
                .aclk     (aclk),
                .en       (adv),
                .cell_in  (sq_in[gi]),
                .cell_out (sq_out[gi])
            );
        end
    endgenerate

    // ---------------- denominator and divider setup ----------------
    logic signed [D_W-1:0] d_reg, d_next;
    side_t                 side3_reg;
    side_t                 side4_reg, side4_next;
    logic [DIV_W-1:0]      n1_reg, n1_next, n2_reg, n2_next;
    logic [D_W:0]          dd_reg, dd_next;
    logic [D_W-1:0]        d_abs;
    logic [SUM_W-1:0]      diff_abs, y2_abs;

    assign d_next = D_W'(sq_side_reg[SQ_CELLS-1].sum)
                  + D_W'({sq_out[SQ_CELLS-1].root, 1'b0});

    always_comb begin
        side4_next      = side3_reg;
        d_abs           = (d_reg < 0) ? D_W'(-d_reg) : D_W'(d_reg);
        diff_abs        = (side3_reg.diff < 0) ? SUM_W'(-side3_reg.diff) : SUM_W'(side3_reg.diff);
        y2_abs          = (side3_reg.y2 < 0) ? SUM_W'(-side3_reg.y2) : SUM_W'(side3_reg.y2);
        // 2*|n| + |d| with n = value * 2^14
        n1_next         = (DIV_W'(diff_abs) << (FRAC_E + 1)) + DIV_W'(d_abs);
        n2_next         = (DIV_W'(y2_abs) << (FRAC_E + 1)) + DIV_W'(d_abs);
        dd_next         = {d_abs, 1'b0};
        side4_next.zero = (d_reg == '0);
        side4_next.sgn1 = side3_reg.diff[SUM_W-1] ^ d_reg[D_W-1];
        side4_next.sgn2 = side3_reg.y2[SUM_W-1] ^ d_reg[D_W-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg     <= d_next;
            side3_reg <= sq_side_reg[SQ_CELLS-1];
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            dd_reg    <= dd_next;
            side4_reg <= side4_next;
        end
    end

    // ---------------- two divider rows ----------------
    div_t  dv1_in  [DIV_CELLS];
    div_t  dv1_out [DIV_CELLS];
    div_t  dv2_in  [DIV_CELLS];
    div_t  dv2_out [DIV_CELLS];
    side_t dv_side_reg [DIV_CELLS];
    side_t dv_side_in;
    logic [DIV_W-1:0] dd_top;

    always_comb begin
        dd_top          = DIV_W'(dd_reg) << DIV_CELLS;
        dv_side_in      = side4_reg;
        dv_side_in.ovf1 = (n1_reg >= dd_top);
        dv_side_in.ovf2 = (n2_reg >= dd_top);
    end

    generate
        for (gi = 0; gi < DIV_CELLS; gi++) begin : g_div
            if (gi == 0) begin : g_first
                assign dv1_in[gi] = '{rem: n1_reg, dv: DVS_W'(dd_reg) << (DIV_CELLS - 1),
                                      quo: '0};
                assign dv2_in[gi] = '{rem: n2_reg, dv: DVS_W'(dd_reg) << (DIV_CELLS - 1),
                                      quo: '0};
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dv_side_reg[gi] <= dv_side_in;
                    end
                end
            end else begin : g_next
                assign dv1_in[gi] = dv1_out[gi-1];
                assign dv2_in[gi] = dv2_out[gi-1];
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dv_side_reg[gi] <= dv_side_reg[gi-1];
                    end
                end
            end
            qe_div_cell u_cell1 (
                .aclk     (aclk),
                .en       (adv),
                .cell_in  (dv1_in[gi]),
                .cell_out (dv1_out[gi])
            );
            qe_div_cell u_cell2 (
                .aclk     (aclk),
                .en       (adv),
                .cell_in  (dv2_in[gi]),
                .cell_out (dv2_out[gi])
            );
        end
    endgenerate

    // ---------------- saturate, square, sum ----------------
    function automatic logic signed [E_W-1:0] sat_quo(input logic [DIV_CELLS-1:0] q,
                                                      input logic ovf, input logic neg);
        logic signed [E_W-1:0] r;
        if (neg) begin
            if (ovf || (q > 16'd32768)) begin
                r = 16'sh8000;
            end else begin
                r = E_W'(17'd0 - {1'b0, q});
            end
        end else begin
            if (ovf || q[DIV_CELLS-1]) begin
                r = 16'sh7FFF;
            end else begin
                r = E_W'(q);
            end
        end
        return r;
    endfunction

    side_t                     side5_reg, side5_next;
    side_t                     side6_reg, side7_reg;
    logic signed [2*E_W-1:0]   sq1_reg, sq2_reg;
    logic [2*E_W-1:0]          sqs_reg;

    always_comb begin
        side5_next    = dv_side_reg[DIV_CELLS-1];
        side5_next.e1 = sat_quo(dv1_out[DIV_CELLS-1].quo, side5_next.ovf1, side5_next.sgn1);
        side5_next.e2 = sat_quo(dv2_out[DIV_CELLS-1].quo, side5_next.ovf2, side5_next.sgn2);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side5_reg <= side5_next;
            sq1_reg   <= side5_reg.e1 * side5_reg.e1;
            sq2_reg   <= side5_reg.e2 * side5_reg.e2;
            side6_reg <= side5_reg;
            sqs_reg   <= (2*E_W)'(sq1_reg) + (2*E_W)'(sq2_reg);
            side7_reg <= side6_reg;
        end
    end

    // ---------------- magnitude root ----------------
    sqrt_t mg_in  [MAG_CELLS];
    sqrt_t mg_out [MAG_CELLS];
    side_t mg_side_reg [MAG_CELLS];

    generate
        for (gi = 0; gi < MAG_CELLS; gi++) begin : g_mag
            if (gi == 0) begin : g_first
                assign mg_in[gi] = '{rem: '0, root: '0,
                                     val: {sqs_reg, {(RAD_W-2*E_W){1'b0}}}};
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        mg_side_reg[gi] <= side7_reg;
                    end
                end
            end else begin : g_next
                assign mg_in[gi] = mg_out[gi-1];
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        mg_side_reg[gi] <= mg_side_reg[gi-1];
                    end
                end
            end
            qe_sqrt_cell u_cell (
                .aclk     (aclk),
                .en       (adv),
                .cell_in  (mg_in[gi]),
                .cell_out (mg_out[gi])
            );
        end
    endgenerate

    side_t           side8_reg, side8_next;
    logic [ROOT_W:0] em_round;

    always_comb begin
        side8_next = mg_side_reg[MAG_CELLS-1];
        // round to nearest: remainder above root means past the half point
        em_round   = {1'b0, mg_out[MAG_CELLS-1].root}
                   + ((REM_W'(mg_out[MAG_CELLS-1].root) < mg_out[MAG_CELLS-1].rem)
                      ? (ROOT_W+1)'(1) : (ROOT_W+1)'(0));
        if (em_round > (ROOT_W+1)'(32767)) begin
            side8_next.em = '1;
        end else begin
            side8_next.em = MAG_W'(em_round);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side8_reg <= side8_next;
        end
    end

    // ---------------- normalizer: lead one of max(|x|,|y|) to bit 40 ----------------
    side_t nm_in  [NORM_STEPS];
    side_t nm_reg [NORM_STEPS];

    generate
        for (gi = 0; gi < NORM_STEPS; gi++) begin : g_norm
            localparam int SH = 1 << (NORM_STEPS - 1 - gi);
            side_t nm_next;
            if (gi == 0) begin : g_first
                assign nm_in[gi] = side8_reg;
            end else begin : g_next
                assign nm_in[gi] = nm_reg[gi-1];
            end
            always_comb begin
                nm_next = nm_in[gi];
                if ((nm_in[gi].cm >> (NORM_MSB + 1 - SH)) == '0) begin
                    nm_next.cx = nm_in[gi].cx <<< SH;
                    nm_next.cy = nm_in[gi].cy <<< SH;
                    nm_next.cm = nm_in[gi].cm << SH;
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    nm_reg[gi] <= nm_next;
                end
            end
        end
    endgenerate

    // ---------------- CORDIC row ----------------
    cordic_t cd_in  [CORDIC_STAGES];
    cordic_t cd_out [CORDIC_STAGES];
    side_t   cd_side_reg [CORDIC_STAGES];

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
            if (gi == 0) begin : g_first
                assign cd_in[gi] = '{x: nm_reg[NORM_STEPS-1].cx, y: nm_reg[NORM_STEPS-1].cy,
                                     z: '0};
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        cd_side_reg[gi] <= nm_reg[NORM_STEPS-1];
                    end
                end
            end else begin : g_next
                assign cd_in[gi] = cd_out[gi-1];
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        cd_side_reg[gi] <= cd_side_reg[gi-1];
                    end
                end
            end
            qe_cordic_cell u_cell (
                .aclk     (aclk),
                .en       (adv),
                .cell_in  (cd_in[gi]),
                .x_shift  (cd_in[gi].x >>> gi),
                .y_shift  (cd_in[gi].y >>> gi),
                .angle    (atan_entry(5'(gi))),
                .cell_out (cd_out[gi])
            );
        end
    endgenerate

    // ---------------- output register ----------------
    side_t                   fin;
    logic [Z_W-1:0]          z_abs;
    logic [Z_W-1:0]          z_round;
    logic [ANG_W-1:0]        uz;
    logic signed [ANG_W-1:0] ang_next;
    logic signed [E_W-1:0]   e1_reg, e2_reg;
    logic [MAG_W-1:0]        em_reg;
    logic signed [ANG_W-1:0] ang_reg;
    status_t                 status_reg, status_next;

    always_comb begin
        fin     = cd_side_reg[CORDIC_STAGES-1];
        z_abs   = (cd_out[CORDIC_STAGES-1].z < 0) ? Z_W'(-cd_out[CORDIC_STAGES-1].z)
                                                 : Z_W'(cd_out[CORDIC_STAGES-1].z);
        z_round = (z_abs + Z_W'(256)) >> 9;
        uz      = (z_round > Z_W'(ANG_LIMIT)) ? ANG_W'(ANG_LIMIT) : ANG_W'(z_round);
        // sign of the angle follows Q12
        if (!fin.cflag || fin.zero) begin
            ang_next = '0;
        end else if (fin.q12neg) begin
            ang_next = -$signed(uz);
        end else begin
            ang_next = $signed(uz);
        end
        if (fin.zero) begin
            status_next = ST_ZERO;
        end else if (fin.neg) begin
            status_next = ST_NEGDET;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg     <= fin.zero ? '0 : fin.e1;
            e2_reg     <= fin.zero ? '0 : fin.e2;
            em_reg     <= fin.zero ? '0 : fin.em;
            ang_reg    <= ang_next;
            status_reg <= status_next;
        end
    end

    assign m_ellip_one      = e1_reg;
    assign m_ellip_two      = e2_reg;
    assign m_ellip_mag      = em_reg;
    assign m_angle_centideg = ang_reg;
    assign m_status         = status_reg;

    // ---------------- checks ----------------
    a_zero_den_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ZERO) |->
            (m_ellip_one == '0) && (m_ellip_two == '0) && (m_ellip_mag == '0)
            && (m_angle_centideg == '0))
        else $error("zero denominator beat carries nonzero fields");

    a_angle_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_centideg <= 14'sd4500) && (m_angle_centideg >= -14'sd4500))
        else $error("angle outside +-45 degrees");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
